/* design/fkwc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the feed table of the knob-to-wiper converter.
package fkwc_pkg;

  localparam int BpCount = 16;
  localparam int BpSlots = 16;
  localparam int BpWidth = 10;
  localparam int SampleWidth = 10;
  localparam int FeedWidth = 14;
  localparam int FifoDepth = 4;
  localparam int FifoPtrWidth = $clog2(FifoDepth);
  localparam int DivBits = 17;

  localparam int RapidFeed = 1200;
  localparam int FeedMax = 16383;
  localparam int WiperMax = 255;
  localparam longint CreepDiv = 10;
  localparam longint FeedRef = 500;
  localparam longint MvFull = 10000;
  localparam longint MvDen = 255;

  // Reciprocals, rounded up; exact over the value ranges that reach them.
  localparam int CreepShift = 20;
  localparam logic [16:0] CreepRecip =
    17'(((64'd1 << CreepShift) + CreepDiv - 64'd1) / CreepDiv);
  localparam int WiperShift = 31;
  localparam logic [22:0] WiperRecip =
    23'(((64'd1 << WiperShift) + FeedRef - 64'd1) / FeedRef);
  localparam int MvShift = 24;
  localparam logic [29:0] MvRecip =
    30'((MvFull * (64'd1 << MvShift) + MvDen - 64'd1) / MvDen);

  typedef logic [BpSlots-1:0][BpWidth-1:0] bp_vec_t;

  typedef enum logic [2:0] {
    REG_BP_0_5    = 3'd0,
    REG_BP_6_11   = 3'd1,
    REG_BP_12_15  = 3'd2,
    REG_WIPER_MIN = 3'd3,
    REG_WIPER_500 = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_RAPID,
    KIND_ZERO,
    KIND_FLAT,
    KIND_SLOPE
  } kind_t;

  // One classified request as it waits between front and back.
  typedef struct packed {
    kind_t       kind;
    logic        creep;
    logic        neg;
    logic [9:0]  nmag;
    logic [9:0]  dmag;
    logic [6:0]  dt;
    logic [8:0]  tlo;
  } entry_t;

  function automatic logic [8:0] feed_point(input logic [3:0] k);
    logic [8:0] v;
    unique case (k)
      4'd0:  v = 9'd0;
      4'd1:  v = 9'd12;
      4'd2:  v = 9'd20;
      4'd3:  v = 9'd31;
      4'd4:  v = 9'd40;
      4'd5:  v = 9'd50;
      4'd6:  v = 9'd63;
      4'd7:  v = 9'd80;
      4'd8:  v = 9'd100;
      4'd9:  v = 9'd125;
      4'd10: v = 9'd160;
      4'd11: v = 9'd200;
      4'd12: v = 9'd250;
      4'd13: v = 9'd315;
      4'd14: v = 9'd400;
      4'd15: v = 9'd500;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/feed_knob_to_wiper_converter.sv */
`timescale 1ns / 1ps
// Knob sample to feed rate and wiper setting: config registers, intake, queue and pipeline.
// Throughput: one request per cycle unless the output stalls; the divide pipeline has 17 stages.
// A 4-entry queue takes requests while the pipeline holds on a stalled output.
// Reset (synchronous): clears all config registers to zero, empties the queue and
// drops every in-flight request.
module feed_knob_to_wiper_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  knob_sample,
  input  logic        rapid_pressed,
  input  logic        creep_pressed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] feed_mm_per_min,
  output logic [7:0]  wiper_position,
  output logic        network_enable,
  output logic [13:0] output_millivolts,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import fkwc_pkg::*;

  logic [59:0] bp_lo;
  logic [59:0] bp_mid;
  logic [39:0] bp_hi;
  logic [7:0]  wiper_min;
  logic [7:0]  wiper_500;
  bp_vec_t     bp;

  entry_t      push_entry;
  entry_t      head;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bp_lo     <= '0;
      bp_mid    <= '0;
      bp_hi     <= '0;
      wiper_min <= '0;
      wiper_500 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BP_0_5:    bp_lo     <= cfg_data;
        REG_BP_6_11:   bp_mid    <= cfg_data;
        REG_BP_12_15:  bp_hi     <= cfg_data[39:0];
        REG_WIPER_MIN: wiper_min <= cfg_data[7:0];
        REG_WIPER_500: wiper_500 <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      bp[i]     = bp_lo[BpWidth*i +: BpWidth];
      bp[i + 6] = bp_mid[BpWidth*i +: BpWidth];
    end
    for (int i = 0; i < 4; i++) begin
      bp[i + 12] = bp_hi[BpWidth*i +: BpWidth];
    end
  end

  fkwc_front u_front (
    .bp            (bp),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .knob_sample   (knob_sample),
    .rapid_pressed (rapid_pressed),
    .creep_pressed (creep_pressed),
    .q_full        (q_full),
    .push          (push),
    .entry         (push_entry)
  );

  fkwc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .pop   (pop),
    .rdata (head),
    .full  (q_full),
    .empty (q_empty)
  );

  fkwc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .q_empty           (q_empty),
    .pop               (pop),
    .wiper_minimum     (wiper_min),
    .wiper_at_500      (wiper_500),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .feed_mm_per_min   (feed_mm_per_min),
    .wiper_position    (wiper_position),
    .network_enable    (network_enable),
    .output_millivolts (output_millivolts)
  );

`ifndef NO_ASSERTIONS
  a_zero_feed_zero_wiper: assert property (@(posedge clk) disable iff (rst)
    (out_valid && feed_mm_per_min == '0) |-> wiper_position == '0)
    else $error("nonzero wiper for zero feed");

  a_enable_matches_wiper: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (network_enable == (wiper_position != '0)))
    else $error("enable flag out of step with wiper");

  a_mv_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> output_millivolts <= 14'd10000)
    else $error("millivolts above full scale");

  a_queue_fills_on_request: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("queue filled without an accepted request");
`endif

endmodule

/* design/fkwc_front.sv */
`timescale 1ns / 1ps
// Intake: finds the breakpoint interval of a sample and classifies the request.
module fkwc_front (
  input  fkwc_pkg::bp_vec_t bp,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [9:0]        knob_sample,
  input  logic              rapid_pressed,
  input  logic              creep_pressed,
  input  logic              q_full,
  output logic              push,
  output fkwc_pkg::entry_t  entry
);
  import fkwc_pkg::*;

  logic [3:0]  k;
  logic [3:0]  k_up;
  logic [9:0]  lo;
  logic [9:0]  hi;
  logic [10:0] dx;
  logic [10:0] db;
  logic [10:0] dx_neg;
  logic [10:0] db_neg;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    // Scan from the top so the lowest matching interval wins.
    k = 4'd0;
    for (int i = BpCount - 2; i >= 0; i--) begin
      if (bp[i] < knob_sample && knob_sample <= bp[i+1]) begin
        k = 4'(i);
      end
    end
    k_up   = 4'(k + 4'd1);
    lo     = bp[k];
    hi     = bp[k_up];
    dx     = {1'b0, knob_sample} - {1'b0, lo};
    db     = {1'b0, hi} - {1'b0, lo};
    dx_neg = ~dx + 11'd1;
    db_neg = ~db + 11'd1;

    entry.creep = creep_pressed;
    entry.neg   = dx[10] ^ db[10];
    entry.nmag  = dx[10] ? dx_neg[9:0] : dx[9:0];
    entry.dmag  = db[10] ? db_neg[9:0] : db[9:0];
    entry.dt    = 7'(feed_point(k_up) - feed_point(k));
    entry.tlo   = feed_point(k);

    priority if (rapid_pressed) begin
      entry.kind = KIND_RAPID;
    end else if (knob_sample < bp[1] || knob_sample == '0) begin
      entry.kind = KIND_ZERO;
    end else if (hi == lo) begin
      entry.kind = KIND_FLAT;
    end else begin
      entry.kind = KIND_SLOPE;
    end
  end

endmodule

/* design/fkwc_fifo.sv */
`timescale 1ns / 1ps
// Short request queue between the intake and the arithmetic pipeline.
module fkwc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fkwc_pkg::entry_t wdata,
  input  logic             pop,
  output fkwc_pkg::entry_t rdata,
  output logic             full,
  output logic             empty
);
  import fkwc_pkg::*;

  entry_t                  slots [FifoDepth];
  logic [FifoPtrWidth-1:0] wr_ptr;
  logic [FifoPtrWidth-1:0] rd_ptr;
  logic [FifoPtrWidth:0]   count;

  assign full  = count == (FifoPtrWidth+1)'(FifoDepth);
  assign empty = count == '0;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/fkwc_back.sv */
`timescale 1ns / 1ps
// Arithmetic pipeline: slope product, bit-serial divide stages, creep, wiper and millivolts.
module fkwc_back (
  input  logic             clk,
  input  logic             rst,
  input  fkwc_pkg::entry_t head,
  input  logic             q_empty,
  output logic             pop,
  input  logic [7:0]       wiper_minimum,
  input  logic [7:0]       wiper_at_500,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [13:0]      feed_mm_per_min,
  output logic [7:0]       wiper_position,
  output logic             network_enable,
  output logic [13:0]      output_millivolts
);
  import fkwc_pkg::*;

  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic        creep;
    logic        neg;
    logic [16:0] num;
    logic [16:0] quo;
    logic [9:0]  rem;
    logic [9:0]  dmag;
    logic [8:0]  tlo;
  } div_t;

  logic en;
  div_t dv [DivBits+1];
  div_t dv_nxt [DivBits];

  // The whole pipeline holds while the output register is full and stalled.
  assign en  = !out_valid || !out_stall;
  assign pop = en && !q_empty;

  // One quotient bit per stage, restoring division.
  always_comb begin
    logic [10:0] trial;
    logic        ge;
    for (int j = 0; j < DivBits; j++) begin
      trial         = {dv[j].rem, dv[j].num[16]};
      ge            = trial >= {1'b0, dv[j].dmag};
      dv_nxt[j]     = dv[j];
      dv_nxt[j].rem = ge ? 10'(trial - {1'b0, dv[j].dmag}) : trial[9:0];
      dv_nxt[j].num = {dv[j].num[15:0], 1'b0};
      dv_nxt[j].quo = {dv[j].quo[15:0], ge};
    end
  end

  // Slope product stage, then the divide stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DivBits; j++) begin
        dv[j].vld <= 1'b0;
      end
    end else if (en) begin
      dv[0].vld   <= !q_empty;
      dv[0].kind  <= head.kind;
      dv[0].creep <= head.creep;
      dv[0].neg   <= head.neg;
      dv[0].num   <= {7'd0, head.nmag} * {10'd0, head.dt};
      dv[0].quo   <= '0;
      dv[0].rem   <= '0;
      dv[0].dmag  <= head.dmag;
      dv[0].tlo   <= head.tlo;
      for (int j = 0; j < DivBits; j++) begin
        dv[j+1] <= dv_nxt[j];
      end
    end
  end

  // Feed before creep.
  logic        f_vld;
  logic [16:0] f_val;
  logic        f_creep;
  logic [17:0] q_ext;
  logic [17:0] q_sgn;
  logic [17:0] q_sum;
  logic [16:0] f_val_next;
  logic        f_creep_next;

  always_comb begin
    q_ext = {1'b0, dv[DivBits].quo};
    q_sgn = dv[DivBits].neg ? (~q_ext + 18'd1) : q_ext;
    q_sum = q_sgn + {9'd0, dv[DivBits].tlo};
    unique case (dv[DivBits].kind)
      KIND_RAPID: begin
        f_val_next   = 17'(RapidFeed);
        f_creep_next = 1'b0;
      end
      KIND_ZERO: begin
        f_val_next   = '0;
        f_creep_next = 1'b0;
      end
      KIND_FLAT: begin
        f_val_next   = {8'd0, dv[DivBits].tlo};
        f_creep_next = dv[DivBits].creep;
      end
      default: begin
        // Negative feed saturates; creep of a non-positive value stays at zero.
        f_val_next   = q_sum[17] ? '0 : q_sum[16:0];
        f_creep_next = dv[DivBits].creep;
      end
    endcase
  end

  // Creep product.
  logic        c_vld;
  logic [16:0] c_val;
  logic        c_creep;
  logic [33:0] c_prod;

  // Clamped feed and wiper product.
  logic        g_vld;
  logic [13:0] g_feed;
  logic [21:0] g_prod;
  logic [16:0] feed_sel;
  logic [13:0] feed_clamp;

  always_comb begin
    feed_sel   = c_creep ? 17'(c_prod >> CreepShift) : c_val;
    feed_clamp = (feed_sel > 17'(FeedMax)) ? 14'(FeedMax) : feed_sel[13:0];
  end

  // Divide by the reference feed.
  logic        h_vld;
  logic [13:0] h_feed;
  logic [44:0] h_prod;

  // Wiper selection.
  logic        i_vld;
  logic [13:0] i_feed;
  logic [7:0]  i_wiper;
  logic [13:0] w_raw;
  logic [7:0]  wiper_next;

  always_comb begin
    w_raw = 14'(h_prod >> WiperShift);
    priority if (h_feed == '0) begin
      wiper_next = '0;
    end else if (w_raw > 14'(WiperMax)) begin
      wiper_next = 8'(WiperMax);
    end else if (w_raw != '0 && w_raw < {6'd0, wiper_minimum}) begin
      wiper_next = wiper_minimum;
    end else begin
      wiper_next = w_raw[7:0];
    end
  end

  // Millivolt product.
  logic        j_vld;
  logic [13:0] j_feed;
  logic [7:0]  j_wiper;
  logic [37:0] j_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld     <= 1'b0;
      c_vld     <= 1'b0;
      g_vld     <= 1'b0;
      h_vld     <= 1'b0;
      i_vld     <= 1'b0;
      j_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f_vld     <= dv[DivBits].vld;
      c_vld     <= f_vld;
      g_vld     <= c_vld;
      h_vld     <= g_vld;
      i_vld     <= h_vld;
      j_vld     <= i_vld;
      out_valid <= j_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_val   <= f_val_next;
      f_creep <= f_creep_next;

      c_val   <= f_val;
      c_creep <= f_creep;
      c_prod  <= f_val * CreepRecip;

      g_feed  <= feed_clamp;
      g_prod  <= feed_clamp * wiper_at_500;

      h_feed  <= g_feed;
      h_prod  <= g_prod * WiperRecip;

      i_feed  <= h_feed;
      i_wiper <= wiper_next;

      j_feed  <= i_feed;
      j_wiper <= i_wiper;
      j_prod  <= i_wiper * MvRecip;

      feed_mm_per_min   <= j_feed;
      wiper_position    <= j_wiper;
      network_enable    <= j_wiper != '0;
      output_millivolts <= 14'(j_prod >> MvShift);
    end
  end

endmodule
